@@ hdl/drb_pkg.sv @@
// Package with shared types and constants of the request batcher.
`default_nettype none
package drb_pkg;
    localparam logic [1:0] KIND_DISPATCH = 2'd0;
    localparam logic [1:0] KIND_WAIT     = 2'd1;
    localparam logic [1:0] KIND_REJECT   = 2'd2;
    localparam logic [31:0] IDLE_WAIT_US = 32'd500000;
    localparam logic [9:0]  NS_PER_US    = 10'd1000;
    localparam logic [1:0] REG_BATCHING  = 2'd0;
    localparam logic [1:0] REG_PREFERRED = 2'd1;
    localparam logic [1:0] REG_MAX_DELAY = 2'd2;
    localparam int MAX_RESULTS = 32;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] size;
        logic [63:0] stamp;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic push;
    } t_cell_ctrl;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_AGE_MUL, ST_AGE_SUB, ST_DIV, ST_WAIT_OUT,
        ST_SUM, ST_EMIT, ST_ONE
    } t_state;
endpackage
`default_nettype wire

@@ hdl/dynamic_request_batcher.sv @@
// Top level of the request batcher: a shifting chain of queue cells and its sequencer.
//
//  channel | signals                    | contents
//  s_axis  | tvalid tready tdata tuser  | request arrival or poll
//  m_axis  | tvalid tready tdata tuser tlast | dispatched tags, waits, refusals
//  cfg     | i_cfg_we i_cfg_idx i_cfg_data   | register writes
//
// An arrival is pushed into the queue. A poll scans the queue one cell at a time;
// a wait answer adds the age, a four-step reciprocal division and the output. A
// dispatch sums the sizes of its items and then sends one item per cycle while
// the output is not stalled.
// Input is taken only in idle while the output register is free or drains.
// Reset empties the queue.
`default_nettype none
module dynamic_request_batcher #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: request_tag[15:0], request_size[31:16], now_ns[95:32]
    input  wire logic [95:0] s_axis_tdata,
    // tuser: mode
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: out_tag[15:0], batch_total[36:16], wait_us[68:37], zero fill
    output logic [71:0]      m_axis_tdata,
    // tuser: kind
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic        r_batching;
    logic [63:0] r_mask;
    logic [31:0] r_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batching <= 1'b1;
            r_mask     <= '0;
            r_delay    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                drb_pkg::REG_BATCHING:  r_batching <= i_cfg_data[0];
                drb_pkg::REG_PREFERRED: r_mask     <= i_cfg_data;
                drb_pkg::REG_MAX_DELAY: r_delay    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Maximum preferred size: highest set bit of the mask.
    logic [5:0] w_maxp;
    always_comb begin
        w_maxp = '0;
        for (int k = 0; k < 64; k++) begin
            if (r_mask[k]) begin
                w_maxp = 6'(k);
            end
        end
    end

    drb_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count;
    logic [20:0]   r_ptotal;
    logic [CW-1:0] r_pcnt;
    logic [CW-1:0] r_idx;
    logic [20:0]   r_ssize;
    logic [CW-1:0] r_scnt;
    logic [20:0]   r_bsize;
    logic [CW-1:0] r_bcnt;
    logic [CW-1:0] r_n;
    logic [20:0]   r_sum;
    logic [63:0]   r_now;
    logic [63:0]   r_limit;
    logic [63:0]   r_age;
    logic          r_ovalid;
    logic [1:0]    r_okind;
    logic [15:0]   r_otag;
    logic [20:0]   r_ototal;
    logic [31:0]   r_owait;
    logic          r_olast;

    drb_pkg::t_cell_ctrl w_ctrl;
    drb_pkg::t_entry     w_new;
    drb_pkg::t_entry     w_cells [QUEUE_DEPTH];
    drb_pkg::t_entry     w_next  [QUEUE_DEPTH];
    drb_pkg::t_entry     w_scan;
    logic [IW-1:0]       w_scan_idx;

    assign w_new.tag   = s_axis_tdata[15:0];
    assign w_new.size  = s_axis_tdata[31:16];
    assign w_new.stamp = s_axis_tdata[95:32];

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        if (g == QUEUE_DEPTH - 1) begin : g_end
            assign w_next[g] = w_cells[g];
        end else begin : g_mid
            assign w_next[g] = w_cells[g+1];
        end
        drb_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_load_here(r_count == CW'(g)),
            .i_new      (w_new),
            .i_next     (w_next[g]),
            .o_entry    (w_cells[g])
        );
    end

    assign w_scan_idx = r_idx[IW-1:0];
    assign w_scan     = w_cells[w_scan_idx];

    logic        w_out_free;
    logic        w_in_acc;
    logic        w_div_start;
    logic        w_div_done;
    logic [31:0] w_quot;
    logic [63:0] w_rem_ns;
    logic [20:0] w_front_sum;
    logic [20:0] w_ssum;

    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == drb_pkg::ST_IDLE) && w_out_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_front_sum   = r_ptotal + 21'(w_cells[0].size);
    assign w_ssum        = r_ssize + 21'(w_scan.size);
    assign w_rem_ns      = r_limit - r_age;

    drb_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_rem_ns[41:0]),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    logic n_ovalid;
    logic [1:0] n_okind;
    logic [15:0] n_otag;
    logic [20:0] n_ototal;
    logic [31:0] n_owait;
    logic n_olast;
    logic [CW-1:0] n_count, n_idx, n_pcnt, n_scnt, n_bcnt, n_n;
    logic [20:0] n_ptotal, n_ssize, n_bsize, n_sum;
    logic [63:0] n_now, n_limit, n_age;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_okind  = r_okind;
        n_otag   = r_otag;
        n_ototal = r_ototal;
        n_owait  = r_owait;
        n_olast  = r_olast;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pcnt   = r_pcnt;
        n_ptotal = r_ptotal;
        n_ssize  = r_ssize;
        n_scnt   = r_scnt;
        n_bsize  = r_bsize;
        n_bcnt   = r_bcnt;
        n_n      = r_n;
        n_sum    = r_sum;
        n_now    = r_now;
        n_limit  = r_limit;
        n_age    = r_age;
        w_ctrl   = '0;
        w_div_start = 1'b0;
        unique case (r_state)
            drb_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_now = w_new.stamp;
                    if (!s_axis_tuser) begin
                        if (r_count >= CW'(QUEUE_DEPTH)) begin
                            n_ovalid = 1'b1;
                            n_okind  = drb_pkg::KIND_REJECT;
                            n_otag   = w_new.tag;
                            n_ototal = '0;
                            n_owait  = '0;
                            n_olast  = 1'b1;
                        end else begin
                            w_ctrl.push = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_ovalid = 1'b1;
                        n_okind  = drb_pkg::KIND_WAIT;
                        n_otag   = '0;
                        n_ototal = '0;
                        n_owait  = drb_pkg::IDLE_WAIT_US;
                        n_olast  = 1'b1;
                    end else if (!r_batching) begin
                        n_n = CW'(1);
                        n_state = drb_pkg::ST_ONE;
                    end else if (w_front_sum >= 21'(w_maxp)) begin
                        if (r_pcnt == '0) begin
                            n_n = CW'(1);
                        end else begin
                            n_n = r_pcnt;
                        end
                        n_state = drb_pkg::ST_ONE;
                    end else begin
                        n_idx   = r_pcnt;
                        n_ssize = r_ptotal;
                        n_scnt  = r_pcnt;
                        n_bsize = '0;
                        n_bcnt  = '0;
                        n_state = drb_pkg::ST_SCAN;
                    end
                end
            end
            drb_pkg::ST_SCAN: begin
                if (r_idx >= r_count || w_ssum > 21'(w_maxp)) begin
                    if (r_bsize != '0) begin
                        n_ptotal = r_bsize;
                        n_pcnt   = r_bcnt;
                        n_n      = r_bcnt;
                        n_state  = drb_pkg::ST_ONE;
                    end else begin
                        n_ptotal = r_ssize;
                        n_pcnt   = r_scnt;
                        n_n      = r_scnt;
                        if (r_scnt == '0 || r_delay == '0) begin
                            n_state = drb_pkg::ST_ONE;
                        end else begin
                            n_state = drb_pkg::ST_AGE_MUL;
                        end
                    end
                end else begin
                    n_ssize = w_ssum;
                    n_scnt  = r_scnt + CW'(1);
                    n_idx   = r_idx + CW'(1);
                    if (w_ssum < 21'd64 && r_mask[w_ssum[5:0]]) begin
                        n_bsize = w_ssum;
                        n_bcnt  = r_scnt + CW'(1);
                    end
                end
            end
            drb_pkg::ST_AGE_MUL: begin
                n_limit = {22'd0, 42'(r_delay) * 42'(drb_pkg::NS_PER_US)};
                n_age   = r_now - w_cells[0].stamp;
                n_state = drb_pkg::ST_AGE_SUB;
            end
            drb_pkg::ST_AGE_SUB: begin
                if (r_age >= r_limit) begin
                    n_state = drb_pkg::ST_ONE;
                end else begin
                    w_div_start = 1'b1;
                    n_state = drb_pkg::ST_DIV;
                end
            end
            drb_pkg::ST_DIV: begin
                if (w_div_done) begin
                    if (w_quot == '0) begin
                        n_state = drb_pkg::ST_ONE;
                    end else begin
                        n_state = drb_pkg::ST_WAIT_OUT;
                    end
                end
            end
            drb_pkg::ST_WAIT_OUT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = drb_pkg::KIND_WAIT;
                    n_otag   = '0;
                    n_ototal = '0;
                    n_owait  = w_quot;
                    n_olast  = 1'b1;
                    n_state  = drb_pkg::ST_IDLE;
                end
            end
            drb_pkg::ST_ONE: begin
                // Clamp the batch to the queue and to the result limit.
                if (r_n > r_count) begin
                    n_n = r_count;
                end
                if (QUEUE_DEPTH > drb_pkg::MAX_RESULTS
                        && n_n > CW'(drb_pkg::MAX_RESULTS)) begin
                    n_n = CW'(drb_pkg::MAX_RESULTS);
                end
                n_idx = '0;
                n_sum = '0;
                if (r_batching) begin
                    n_ptotal = '0;
                    n_pcnt   = '0;
                end
                n_state = drb_pkg::ST_SUM;
            end
            drb_pkg::ST_SUM: begin
                if (r_idx == r_n) begin
                    if (r_n == '0) begin
                        if (w_out_free) begin
                            n_ovalid = 1'b1;
                            n_okind  = drb_pkg::KIND_WAIT;
                            n_otag   = '0;
                            n_ototal = '0;
                            n_owait  = '0;
                            n_olast  = 1'b1;
                            n_state  = drb_pkg::ST_IDLE;
                        end
                    end else begin
                        n_idx   = '0;
                        n_state = drb_pkg::ST_EMIT;
                    end
                end else begin
                    n_sum = r_sum + 21'(w_scan.size);
                    n_idx = r_idx + CW'(1);
                end
            end
            drb_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = drb_pkg::KIND_DISPATCH;
                    n_otag   = w_cells[0].tag;
                    n_ototal = r_sum;
                    n_owait  = '0;
                    n_olast  = (r_idx + CW'(1)) == r_n;
                    w_ctrl.shift = 1'b1;
                    n_count = r_count - CW'(1);
                    n_idx   = r_idx + CW'(1);
                    if ((r_idx + CW'(1)) == r_n) begin
                        n_state = drb_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = drb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= drb_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_count  <= '0;
            r_ptotal <= '0;
            r_pcnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_count  <= n_count;
            r_ptotal <= n_ptotal;
            r_pcnt   <= n_pcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_okind  <= n_okind;
        r_otag   <= n_otag;
        r_ototal <= n_ototal;
        r_owait  <= n_owait;
        r_olast  <= n_olast;
        r_idx    <= n_idx;
        r_ssize  <= n_ssize;
        r_scnt   <= n_scnt;
        r_bsize  <= n_bsize;
        r_bcnt   <= n_bcnt;
        r_n      <= n_n;
        r_sum    <= n_sum;
        r_now    <= n_now;
        r_limit  <= n_limit;
        r_age    <= n_age;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b000, r_owait, r_ototal, r_otag};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;
endmodule
`default_nettype wire

@@ hdl/drb_cell.sv @@
// One queue cell: holds one entry and hands it toward the front of the chain.
`default_nettype none
module drb_cell (
    input  wire logic                i_clk,
    input  wire drb_pkg::t_cell_ctrl i_ctrl,
    input  wire logic                i_load_here,
    input  wire drb_pkg::t_entry     i_new,
    input  wire drb_pkg::t_entry     i_next,
    output drb_pkg::t_entry          o_entry
);
    drb_pkg::t_entry r_entry;
    drb_pkg::t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.shift) begin
            n_entry = i_next;
        end
        if (i_ctrl.push && i_load_here) begin
            n_entry = i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
endmodule
`default_nettype wire

@@ hdl/drb_div.sv @@
// Divider of a wait in nanoseconds by ns per us, by reciprocal multiplication in four steps.
`default_nettype none
module drb_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [41:0] i_num,
    output logic             o_done,
    output logic [31:0]      o_quot
);
    // The value 2^35 / 125 rounded up gives exact quotients for dividends below 2^31.
    localparam logic [28:0] RECIP_125 = 29'd274877907;

    logic [20:0] r_xh;
    logic [20:0] r_xl;
    logic [10:0] r_q1;
    logic [30:0] r_z;
    logic [20:0] r_q2;
    logic [1:0]  r_step;
    logic        r_busy;
    logic [21:0] w_q1_full;
    logic [21:0] w_q2_full;
    logic [20:0] w_r1;

    function automatic logic [21:0] f_div1000(logic [30:0] z);
        logic [56:0] p;
        p = 57'(z[30:3]) * 57'(RECIP_125);
        return p[56:35];
    endfunction

    assign w_q1_full = f_div1000({10'd0, r_xh});
    assign w_r1      = r_xh - 21'(r_q1) * 21'(drb_pkg::NS_PER_US);
    assign w_q2_full = f_div1000(r_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= 2'd0;
            r_xh   <= i_num[41:21];
            r_xl   <= i_num[20:0];
        end else if (r_busy) begin
            unique case (r_step)
                2'd0: r_q1 <= w_q1_full[10:0];
                2'd1: r_z  <= {w_r1[9:0], r_xl};
                2'd2: r_q2 <= w_q2_full[20:0];
                2'd3: r_busy <= 1'b0;
            endcase
            r_step <= r_step + 2'd1;
        end
    end

    assign o_done = r_busy && (r_step == 2'd3);
    assign o_quot = {r_q1, r_q2};
endmodule
`default_nettype wire
